// ===== design/r16ex_pkg.sv =====
// r16ex_pkg: shared types and codes for the 16-bit risc execute stage
// used by the channel interfaces and by risc16_execute_stage
`timescale 1ns / 1ps
`default_nettype none

package r16ex_pkg;

    // alu command codes
    localparam logic [4:0] CMD_ADD   = 5'd0;
    localparam logic [4:0] CMD_ADDI  = 5'd1;
    localparam logic [4:0] CMD_ADDU  = 5'd2;
    localparam logic [4:0] CMD_ADDUI = 5'd3;
    localparam logic [4:0] CMD_ADDC  = 5'd4;
    localparam logic [4:0] CMD_ADDCI = 5'd5;
    localparam logic [4:0] CMD_SUB   = 5'd6;
    localparam logic [4:0] CMD_SUBI  = 5'd7;
    localparam logic [4:0] CMD_SUBC  = 5'd8;
    localparam logic [4:0] CMD_SUBCI = 5'd9;
    localparam logic [4:0] CMD_MUL   = 5'd10;
    localparam logic [4:0] CMD_MULI  = 5'd11;
    localparam logic [4:0] CMD_CMP   = 5'd12;
    localparam logic [4:0] CMD_CMPI  = 5'd13;
    localparam logic [4:0] CMD_AND   = 5'd14;
    localparam logic [4:0] CMD_ANDI  = 5'd15;
    localparam logic [4:0] CMD_OR    = 5'd16;
    localparam logic [4:0] CMD_ORI   = 5'd17;
    localparam logic [4:0] CMD_XOR   = 5'd18;
    localparam logic [4:0] CMD_XORI  = 5'd19;
    localparam logic [4:0] CMD_MOV   = 5'd20;
    localparam logic [4:0] CMD_MOVI  = 5'd21;
    localparam logic [4:0] CMD_LSH   = 5'd22;
    localparam logic [4:0] CMD_LSHI  = 5'd23;
    localparam logic [4:0] CMD_ASH   = 5'd24;
    localparam logic [4:0] CMD_ASHI  = 5'd25;
    localparam logic [4:0] CMD_LUI   = 5'd26;
    localparam logic [4:0] CMD_LOAD  = 5'd27;
    localparam logic [4:0] CMD_STOR  = 5'd28;
    localparam logic [4:0] CMD_BCOND = 5'd29;
    localparam logic [4:0] CMD_JCOND = 5'd30;
    localparam logic [4:0] CMD_JAL   = 5'd31;

    // branch condition codes carried in dest_index
    localparam logic [3:0] COND_EQ  = 4'd0;
    localparam logic [3:0] COND_NE  = 4'd1;
    localparam logic [3:0] COND_CS  = 4'd2;
    localparam logic [3:0] COND_CC  = 4'd3;
    localparam logic [3:0] COND_MI  = 4'd6;
    localparam logic [3:0] COND_PL  = 4'd7;
    localparam logic [3:0] COND_VS  = 4'd8;
    localparam logic [3:0] COND_VC  = 4'd9;
    localparam logic [3:0] COND_LE  = 4'd11;
    localparam logic [3:0] COND_GT  = 4'd12;
    localparam logic [3:0] COND_AL  = 4'd14;

    typedef struct packed {
        logic [4:0]  command;
        logic        flush;
        logic        use_immediate;
        logic        subtract;
        logic        move_op;
        logic        use_carry;
        logic [1:0]  memory_mode;
        logic [15:0] immediate;
        logic [15:0] source_value;
        logic [15:0] dest_value;
        logic [15:0] pc_value;
        logic [3:0]  dest_index;
    } instr_word_t;

    typedef struct packed {
        logic [15:0] alu_result;
        logic [15:0] next_pc;
        logic        branch_op;
        logic [3:0]  dest_index_out;
        logic [15:0] store_data;
        logic [15:0] mem_address;
        logic        carry_flag;
        logic        zero_flag;
        logic        negative_flag;
        logic        overflow_flag;
    } result_word_t;

endpackage

`default_nettype wire

// ===== design/r16ex_instr_if.sv =====
// r16ex_instr_if: valid/ready channel carrying one decoded instruction word
// depends on r16ex_pkg
`timescale 1ns / 1ps
`default_nettype none

interface r16ex_instr_if import r16ex_pkg::*; ();
    logic        valid;
    logic        ready;
    instr_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/r16ex_result_if.sv =====
// r16ex_result_if: valid/ready channel carrying one execute result word
// depends on r16ex_pkg
`timescale 1ns / 1ps
`default_nettype none

interface r16ex_result_if import r16ex_pkg::*; ();
    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/risc16_execute_stage.sv =====
// risc16_execute_stage: alu, flags, branch target and memory outputs of a 16-bit risc
// depends on r16ex_pkg, r16ex_instr_if and r16ex_result_if
`timescale 1ns / 1ps
`default_nettype none

// Takes one instruction word per cycle unless stalled and returns one result word
// for each, in order. The word is held in an input register, the alu, the 16x16
// multiplier and the flag update work on it there, and the result goes to an output
// register; the carry/zero/negative/overflow flags change as each word passes that
// step, so a following word sees them at once. A stalled output holds the pipe: the
// input register keeps its word and instr.ready drops only when both registers are
// full and result.ready is low. Flags reset to zero; a flush word returns all zeros
// and leaves the flags alone.
module risc16_execute_stage import r16ex_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    r16ex_instr_if.sink   instr,
    r16ex_result_if.source result
);

    logic         s1_valid_reg;
    instr_word_t  s1_reg;
    logic         out_valid_reg;
    result_word_t out_reg;
    logic         carry_reg;
    logic         zero_reg;
    logic         negative_reg;
    logic         overflow_reg;

    logic         advance;
    logic         carry_next;
    logic         zero_next;
    logic         negative_next;
    logic         overflow_next;
    result_word_t out_next;

    logic [15:0] imm_ext;
    logic [15:0] a_sel;
    logic [15:0] op_a;
    logic [15:0] op_b;
    logic [1:0]  cin;
    logic [16:0] sum;
    logic [15:0] sum_low_byte;
    logic [15:0] product;
    logic [15:0] neg_a;
    logic [4:0]  neg_a5;
    logic        shift_right_imm;
    logic        cond_ok;
    logic [15:0] res;
    logic [15:0] npc;
    logic        br;

    function automatic logic [15:0] shl16(input logic [15:0] v, input logic [15:0] n);
        logic [15:0] r;
        if (n >= 16'd16)
            r = '0;
        else
            r = v << n[3:0];
        return r;
    endfunction

    function automatic logic [15:0] shr16(input logic [15:0] v, input logic [15:0] n,
                                         input logic arith);
        logic [15:0] fill;
        logic [15:0] r;
        fill = (arith && v[15]) ? 16'hFFFF : 16'h0000;
        if (n >= 16'd16)
            r = fill;
        else if (arith)
            r = 16'($signed(v) >>> n[3:0]);
        else
            r = v >> n[3:0];
        return r;
    endfunction

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready  = !s1_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // operand selection
    assign imm_ext      = {{8{s1_reg.immediate[7]}}, s1_reg.immediate[7:0]};
    assign a_sel        = s1_reg.use_immediate ? imm_ext : s1_reg.source_value;
    assign op_a         = s1_reg.subtract ? ~a_sel : a_sel;
    assign op_b         = s1_reg.move_op ? 16'h0000 : s1_reg.dest_value;
    assign cin          = {1'b0, s1_reg.subtract} + {1'b0, s1_reg.use_carry & carry_reg};
    assign sum          = {1'b0, op_a} + {1'b0, op_b} + {15'b0, cin};
    assign sum_low_byte = {8'h00, op_a[7:0]} + op_b + {14'b0, cin};
    // only the low half of the product is used
    assign product      = op_a * op_b;
    assign neg_a        = 16'h0000 - op_a;
    assign neg_a5       = 5'd0 - op_a[4:0];
    assign shift_right_imm = s1_reg.use_immediate && s1_reg.immediate[4];

    always_comb
    begin
        unique case (s1_reg.dest_index)
            COND_EQ: cond_ok = zero_reg;
            COND_NE: cond_ok = !zero_reg;
            COND_CS: cond_ok = carry_reg;
            COND_CC: cond_ok = !carry_reg;
            COND_MI: cond_ok = negative_reg;
            COND_PL: cond_ok = !negative_reg;
            COND_VS: cond_ok = overflow_reg;
            COND_VC: cond_ok = !overflow_reg;
            COND_LE: cond_ok = zero_reg || negative_reg;
            COND_GT: cond_ok = !zero_reg && !negative_reg;
            COND_AL: cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        res           = '0;
        npc           = s1_reg.pc_value;
        br            = 1'b0;
        carry_next    = carry_reg;
        zero_next     = zero_reg;
        negative_next = negative_reg;
        overflow_next = overflow_reg;
        unique case (s1_reg.command) inside
            CMD_ADD, CMD_ADDI, CMD_ADDC, CMD_ADDCI, CMD_SUB, CMD_SUBI, CMD_SUBC, CMD_SUBCI:
            begin
                res           = sum[15:0];
                overflow_next = ~(op_a[15] ^ op_b[15]) & (op_a[15] ^ sum[15]);
            end
            CMD_ADDU, CMD_ADDUI:
            begin
                res        = sum[15:0];
                carry_next = sum[16];
            end
            CMD_MUL, CMD_MULI:
            begin
                res = product;
            end
            CMD_CMP, CMD_CMPI:
            begin
                res           = sum[15:0];
                zero_next     = (sum[15:0] == 16'h0000);
                negative_next = sum[15];
            end
            CMD_AND, CMD_ANDI: res = op_a & op_b;
            CMD_OR:            res = op_a | op_b;
            CMD_ORI:           res = {8'h00, op_a[7:0]} | op_b;
            CMD_XOR:           res = op_a ^ op_b;
            CMD_XORI:          res = {8'h00, op_a[7:0]} ^ op_b;
            CMD_MOV:           res = sum[15:0];
            CMD_MOVI:          res = sum_low_byte;
            CMD_LSH, CMD_ASH:
            begin
                // negative amount means a right shift by its magnitude
                if (op_a[15])
                    res = shr16(op_b, neg_a, s1_reg.command == CMD_ASH);
                else
                    res = shl16(op_b, op_a);
            end
            CMD_LSHI, CMD_ASHI:
            begin
                if (shift_right_imm)
                    res = shr16(op_b, {11'b0, neg_a5}, s1_reg.command == CMD_ASHI);
                else
                    res = shl16(op_b, {12'b0, op_a[3:0]});
            end
            CMD_LUI:            res = {op_a[7:0], 8'h00};
            CMD_LOAD, CMD_STOR: res = op_a;
            CMD_BCOND:
            begin
                br = 1'b1;
                if (cond_ok)
                    npc = s1_reg.pc_value + op_a;
            end
            CMD_JCOND:
            begin
                br = 1'b1;
                if (cond_ok)
                    npc = {1'b0, op_a[15:1]};
            end
            default:
            begin
                // jump and link
                br  = 1'b1;
                res = s1_reg.pc_value;
                npc = {1'b0, op_b[15:1]};
            end
        endcase
    end

    always_comb
    begin
        if (s1_reg.flush)
        begin
            out_next = '0;
        end
        else
        begin
            out_next.alu_result     = res;
            out_next.next_pc        = npc;
            out_next.branch_op      = br;
            out_next.dest_index_out = s1_reg.dest_index;
            out_next.store_data     = s1_reg.memory_mode[0] ? op_b : 16'h0000;
            out_next.mem_address    = s1_reg.memory_mode[1] ? res : 16'h0000;
            out_next.carry_flag     = carry_next;
            out_next.zero_flag      = zero_next;
            out_next.negative_flag  = negative_next;
            out_next.overflow_flag  = overflow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            carry_reg     <= 1'b0;
            zero_reg      <= 1'b0;
            negative_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (instr.ready)
                s1_valid_reg <= instr.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (advance && !s1_reg.flush)
            begin
                carry_reg    <= carry_next;
                zero_reg     <= zero_next;
                negative_reg <= negative_next;
                overflow_reg <= overflow_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr.valid && instr.ready)
            s1_reg <= instr.data;
        if (advance)
            out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    // a flushed word must not disturb the flags
    a_flush_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_reg.flush
        |=> $stable({carry_reg, zero_reg, negative_reg, overflow_reg}))
        else $error("flags changed on a flushed word");

    // reported flags match the flag registers just after a live word moves out
    a_flags_reported: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !s1_reg.flush
        |=> out_reg.carry_flag == carry_reg && out_reg.zero_flag == zero_reg
            && out_reg.negative_flag == negative_reg
            && out_reg.overflow_flag == overflow_reg)
        else $error("reported flags differ from flag state");

    // non-branch commands leave the pc alone
    a_no_branch_pc: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !s1_reg.flush && s1_reg.command < CMD_BCOND
        |=> out_reg.next_pc == $past(s1_reg.pc_value) && !out_reg.branch_op)
        else $error("next pc changed by a non-branch command");

    // an empty output register never blocks the input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> instr.ready)
        else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire
